@@ src/vector_normalize_to_radius_defines.svh @@
// Assertion macros for the vector normalizer.
// Each macro expects clk and rst_n in scope.
`ifndef VECTOR_NORMALIZE_TO_RADIUS_DEFINES_SVH
`define VECTOR_NORMALIZE_TO_RADIUS_DEFINES_SVH

// Condition a implies condition b in the same cycle.
`define VNR_ASSERT_IMPLIES(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Condition c holds at every edge out of reset.
`define VNR_ASSERT_ALWAYS(lbl, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) else $error(msg);

`endif

@@ src/vnr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnr_pkg: shared types and step functions
// Word types, pipeline sideband, and the square-root and divide steps.
// ----------------------------------------------------------------------------
package vnr_pkg;

  localparam int RADIUS_W    = 31;
  localparam int SQRT_STAGES = 16;  // two root bits per stage
  localparam int DIV_STAGES  = 16;  // two quotient bits per stage
  localparam int LATENCY     = 3 + SQRT_STAGES + 1 + DIV_STAGES + 1;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_length;
  } out_word_t;

  // Sideband that rides along with each vector.
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             zero;
  } vec_meta_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] n;  // dividend bits out at top, quotient bits in at bottom
  } div_acc_t;

  // One restoring square-root step on the next two radicand bits.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [34:0] rem_s;
    logic [34:0] trial;
    sqrt_acc_t   res;
    rem_s = {a.rem[32:0], pair};
    trial = {1'b0, a.root, 2'b01};
    if (rem_s >= trial) begin
      res.rem  = rem_s - trial;
      res.root = {a.root[30:0], 1'b1};
    end else begin
      res.rem  = rem_s;
      res.root = {a.root[30:0], 1'b0};
    end
    return res;
  endfunction

  // One restoring divide step; r stays below d when it starts below d.
  function automatic div_acc_t div_step(div_acc_t a, logic [31:0] d);
    logic [32:0] t;
    div_acc_t    res;
    t = {a.r, a.n[31]};
    if (t >= {1'b0, d}) begin
      res.r = 32'(t - {1'b0, d});
      res.n = {a.n[30:0], 1'b1};
    end else begin
      res.r = t[31:0];
      res.n = {a.n[30:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ src/vnr_sumsq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnr_sumsq: magnitude, squares and sum of squares
// Three stages: sign split, one 32x32 square per lane, 64-bit sum.
// ----------------------------------------------------------------------------
module vnr_sumsq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  vnr_pkg::in_word_t  in_word,
  output logic               sum_valid,
  output logic [63:0]        sum,
  output vnr_pkg::vec_meta_t sum_meta
);

  logic               v1_r, v2_r, v3_r;
  vnr_pkg::vec_meta_t m1_r, m1_nxt, m2_r, m3_r, m3_nxt;
  logic [2:0][63:0]   sq_r, sq_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [2:0][31:0]   raw;

  assign raw = {in_word.in_x, in_word.in_y, in_word.in_z};

  // Sign and magnitude; the most negative word maps to 2^31
  always_comb begin
    m1_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      m1_nxt.neg[k] = raw[k][31];
      m1_nxt.mag[k] = raw[k][31] ? 32'(-raw[k]) : raw[k];
    end
  end

  // Lane squares
  always_comb begin
    for (int k = 0; k < 3; k++) sq_nxt[k] = 64'(m1_r.mag[k]) * 64'(m1_r.mag[k]);
  end

  // Sum (at most 3 * 2^62, no overflow) and zero detect
  always_comb begin
    sum_nxt     = sq_r[0] + sq_r[1] + sq_r[2];
    m3_nxt      = m2_r;
    m3_nxt.zero = (sum_nxt == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r  <= m1_nxt;
    sq_r  <= sq_nxt;
    m2_r  <= m1_r;
    sum_r <= sum_nxt;
    m3_r  <= m3_nxt;
  end

  assign sum_valid = v3_r;
  assign sum       = sum_r;
  assign sum_meta  = m3_r;

endmodule

@@ src/vnr_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnr_sqrt: pipelined floor square root
// Restoring digit-by-digit root of a 64-bit value, two bits per stage.
// ----------------------------------------------------------------------------
module vnr_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sum_valid,
  input  logic [63:0]        sum,
  input  vnr_pkg::vec_meta_t sum_meta,
  output logic               root_valid,
  output logic [31:0]        root,
  output vnr_pkg::vec_meta_t root_meta
);

  localparam int N = vnr_pkg::SQRT_STAGES;

  logic               v_r   [N+1];
  vnr_pkg::sqrt_acc_t acc_r [N+1];
  logic [63:0]        rad_r [N+1];  // radicand bits not yet consumed
  vnr_pkg::vec_meta_t meta_r[N+1];

  assign v_r[0]    = sum_valid;
  assign acc_r[0]  = '0;
  assign rad_r[0]  = sum;
  assign meta_r[0] = sum_meta;

  for (genvar g = 0; g < N; g++) begin : g_stage
    vnr_pkg::sqrt_acc_t acc_nxt;

    // Two root bits per stage
    always_comb begin
      acc_nxt = vnr_pkg::sqrt_step(acc_r[g], rad_r[g][63:62]);
      acc_nxt = vnr_pkg::sqrt_step(acc_nxt, rad_r[g][61:60]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      acc_r[g+1]  <= acc_nxt;
      rad_r[g+1]  <= {rad_r[g][59:0], 4'b0000};
      meta_r[g+1] <= meta_r[g];
    end
  end

  assign root_valid = v_r[N];
  assign root       = acc_r[N].root;
  assign root_meta  = meta_r[N];

endmodule

@@ src/vnr_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnr_scale: component scaling
// Per lane: product with radius, 32-bit restoring divide by the length,
// then sign, clamp and zero-vector bypass.
// ----------------------------------------------------------------------------
module vnr_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          root_valid,
  input  logic [31:0]                   root,
  input  vnr_pkg::vec_meta_t            root_meta,
  input  logic [vnr_pkg::RADIUS_W-1:0]  radius,
  output logic                          out_valid,
  output vnr_pkg::out_word_t            out_word
);

  localparam int N = vnr_pkg::DIV_STAGES;

  typedef vnr_pkg::div_acc_t [2:0] div_lanes_t;

  logic                  v_r   [N+1];
  div_lanes_t            acc_r [N+1];
  logic [31:0]           d_r   [N+1];
  logic [2:0]            neg_r [N+1];
  logic                  zero_r[N+1];
  div_lanes_t            acc0_nxt;
  logic                  vo_r;
  vnr_pkg::out_word_t    ow_r, ow_nxt;

  // Product stage: one 32x31 multiplier per lane
  always_comb begin
    logic [62:0] p;
    for (int k = 0; k < 3; k++) begin
      p             = 63'(root_meta.mag[k]) * 63'(radius);
      acc0_nxt[k].r = {1'b0, p[62:32]};
      acc0_nxt[k].n = p[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    acc_r[0]  <= acc0_nxt;
    d_r[0]    <= root;
    neg_r[0]  <= root_meta.neg;
    zero_r[0] <= root_meta.zero;
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    div_lanes_t acc_nxt;

    // Two quotient bits per lane per stage
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        acc_nxt[k] = vnr_pkg::div_step(acc_r[g][k], d_r[g]);
        acc_nxt[k] = vnr_pkg::div_step(acc_nxt[k], d_r[g]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      acc_r[g+1]  <= acc_nxt;
      d_r[g+1]    <= d_r[g];
      neg_r[g+1]  <= neg_r[g];
      zero_r[g+1] <= zero_r[g];
    end
  end

  // Sign, clamp, zero-vector bypass (input was all zero, so output is zero)
  always_comb begin
    logic [31:0]      q;
    logic [2:0][31:0] res;
    for (int k = 0; k < 3; k++) begin
      q = acc_r[N][k].n;
      if (neg_r[N][k]) begin
        res[k] = (q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      end else begin
        res[k] = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
      end
      if (zero_r[N]) res[k] = '0;
    end
    ow_nxt.out_x       = res[2];
    ow_nxt.out_y       = res[1];
    ow_nxt.out_z       = res[0];
    ow_nxt.zero_length = zero_r[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
  end

  assign out_valid = vo_r;
  assign out_word  = ow_r;

endmodule

@@ src/vector_normalize_to_radius.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_to_radius: scale a Q16.16 3D vector to a set length
// Length is floor(sqrt(x^2+y^2+z^2)); each component becomes
// trunc(c * radius / length), clamped; an all-zero vector passes through.
// ----------------------------------------------------------------------------
// Channel  | Ports                          | Handshake
// input    | start, busy, in_data           | taken when start && !busy
// result   | out_valid, out_data            | one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_data | written when cfg_valid && cfg_ready
//
// One word enters per cycle; each result passes through the
// 3 sum-of-squares stages, 16 root stages (two bits each), the product
// stage, 16 divide stages (two bits each) and the output register.
// busy stays low; the pipeline never stalls. Reset clears all valid bits
// and sets the radius to 1.0. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "vector_normalize_to_radius_defines.svh"

module vector_normalize_to_radius (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  vnr_pkg::in_word_t            in_data,
  output logic                         out_valid,
  output vnr_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vnr_pkg::RADIUS_W-1:0] cfg_data
);

  logic [vnr_pkg::RADIUS_W-1:0] radius_r;
  logic                         sum_valid, root_valid;
  logic [63:0]                  sum;
  logic [31:0]                  root;
  vnr_pkg::vec_meta_t           sum_meta, root_meta;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= vnr_pkg::RADIUS_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_data;
    end
  end

  vnr_sumsq u_sumsq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_word   (in_data),
    .sum_valid (sum_valid),
    .sum       (sum),
    .sum_meta  (sum_meta)
  );

  vnr_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .sum_meta   (sum_meta),
    .root_valid (root_valid),
    .root       (root),
    .root_meta  (root_meta)
  );

  vnr_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .root_valid (root_valid),
    .root       (root),
    .root_meta  (root_meta),
    .radius     (radius_r),
    .out_valid  (out_valid),
    .out_word   (out_data)
  );

  // Checks
  `VNR_ASSERT_IMPLIES(a_zero_out, out_valid && out_data.zero_length, out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0, "zero vector not passed through")
  `VNR_ASSERT_IMPLIES(a_no_clamp, out_valid, out_data.out_x != 32'sh8000_0000 && out_data.out_y != 32'sh8000_0000 && out_data.out_z != 32'sh8000_0000, "component exceeds radius")
  `VNR_ASSERT_IMPLIES(a_root_nz, root_valid && !root_meta.zero, root != 32'd0, "nonzero vector has zero length")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for vector_normalize_to_radius
// Drives Q16.16 vectors through the normalizer, predicts each scaled vector
// by its integer model or typed-in row; compares every word field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    N_RANDOM       = 1520;
  localparam int    N_ROWS         = 22;
  localparam int    INT_MIN        = 32'sh8000_0000;
  localparam int    INT_MAX        = 32'sh7fff_ffff;
  localparam [30:0] RADIUS_MAX     = 31'h7fff_ffff;
  localparam [30:0] RADIUS_ONE     = 31'd65536;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  vnr_pkg::in_word_t in_data;
  logic out_valid;
  vnr_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [vnr_pkg::RADIUS_W-1:0] cfg_data;

  logic [30:0]        radius_q;
  vnr_pkg::out_word_t scaled_q[$];
  int                 n_fail;
  int                 idle_cycles;

  // Directed rows; check_row marks rows whose result is typed in.
  typedef struct {
    logic [30:0]        radius;
    vnr_pkg::in_word_t  vec;
    bit                 check_row;
    vnr_pkg::out_word_t result;
  } vec_row_t;

  vec_row_t rows[N_ROWS];

  vector_normalize_to_radius i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Floor square root, bit by bit.
  function automatic logic [63:0] isqrt64(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Expected scaled vector for one input word under a given radius.
  function automatic vnr_pkg::out_word_t normalize_vec(vnr_pkg::in_word_t v,
                                                       logic [30:0] radius);
    logic [31:0]        comp[3];
    logic [63:0]        mag[3];
    logic [63:0]        sum;
    logic [63:0]        len;
    logic [63:0]        q;
    logic [31:0]        res[3];
    vnr_pkg::out_word_t o;
    comp[0] = v.in_x;
    comp[1] = v.in_y;
    comp[2] = v.in_z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][31] ? 64'(33'h1_0000_0000 - {1'b0, comp[i]}) : 64'(comp[i]);
      sum    = sum + mag[i] * mag[i];
    end
    if (sum == 0) begin
      o = '{out_x: v.in_x, out_y: v.in_y, out_z: v.in_z, zero_length: 1'b1};
      return o;
    end
    len = isqrt64(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'(radius)) / len;
      if (comp[i][31]) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        res[i] = 32'(64'd0 - q);
      end else begin
        if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
        res[i] = q[31:0];
      end
    end
    o = '{out_x: res[0], out_y: res[1], out_z: res[2], zero_length: 1'b0};
    return o;
  endfunction

  function automatic vnr_pkg::in_word_t mk_vec(int x, int y, int z);
    vnr_pkg::in_word_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    return v;
  endfunction

  // Random component: full range, small, extremes, or zero.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 32'($urandom_range(0, 1) ? INT_MIN : INT_MAX);
      1: return 32'd0;
      2, 3: return 32'($signed($urandom_range(0, 8191)) - 4096);
      4: return 32'($signed($urandom_range(0, 255)) - 128);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return RADIUS_MAX;
      2: return RADIUS_ONE;
      3: return 31'($urandom_range(1, 1 << 20));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 3) != 0) return;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one vector; queue its expected result.
  task automatic send_vec(vnr_pkg::in_word_t v, bit typed, vnr_pkg::out_word_t typed_res);
    vnr_pkg::out_word_t exp_w;
    idle_gap();
    start   <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_w    = typed ? typed_res : normalize_vec(v, radius_q);
    scaled_q = {scaled_q, exp_w};
  endtask

  // Radius write: only after the pipeline has drained.
  task automatic write_radius(logic [30:0] r);
    start <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (vnr_pkg::LATENCY + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    radius_q = r;
  endtask

  // Result checker.
  always @(posedge clk) begin
    vnr_pkg::out_word_t e;
    if (rst_n && out_valid) begin
      if (scaled_q.size() == 0) begin
        $error("unexpected output word %h", out_data);
        n_fail++;
      end else begin
        e = scaled_q.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x exp %h got %h", e.out_x, out_data.out_x);
          n_fail++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y exp %h got %h", e.out_y, out_data.out_y);
          n_fail++;
        end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z exp %h got %h", e.out_z, out_data.out_z);
          n_fail++;
        end
        if (out_data.zero_length !== e.zero_length) begin
          $error("zero_length exp %b got %b", e.zero_length, out_data.zero_length);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word, output or radius write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    vnr_pkg::out_word_t zero_res;
    vnr_pkg::out_word_t unit_x;
    vnr_pkg::out_word_t unit_nz;
    vnr_pkg::out_word_t none_res;
    logic [30:0] r;
    n_fail      = 0;
    idle_cycles = 0;
    radius_q    = RADIUS_ONE;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;

    zero_res = '{out_x: 0, out_y: 0, out_z: 0, zero_length: 1'b1};
    unit_x   = '{out_x: 32'd65536, out_y: 0, out_z: 0, zero_length: 1'b0};
    unit_nz  = '{out_x: 0, out_y: 0, out_z: -32'sd65536, zero_length: 1'b0};
    none_res = '{out_x: 0, out_y: 0, out_z: 0, zero_length: 1'b0};

    // Zero vector, axis extremes, other vectors; unit, zero, max and other radii.
    rows = '{
      '{RADIUS_ONE, mk_vec(0, 0, 0), 1, zero_res},
      '{RADIUS_ONE, mk_vec(INT_MAX, 0, 0), 1, unit_x},
      '{RADIUS_ONE, mk_vec(0, 0, INT_MIN), 1, unit_nz},
      '{RADIUS_ONE, mk_vec(1, 0, 0), 1, unit_x},
      '{RADIUS_ONE, mk_vec(0, 0, -1), 1, unit_nz},
      '{RADIUS_ONE, mk_vec(INT_MIN, INT_MIN, INT_MIN), 0, none_res},
      '{RADIUS_ONE, mk_vec(INT_MAX, INT_MAX, INT_MAX), 0, none_res},
      '{RADIUS_ONE, mk_vec(INT_MAX, INT_MIN, 1), 0, none_res},
      '{RADIUS_ONE, mk_vec(3, 4, 0), 0, none_res},
      '{RADIUS_ONE, mk_vec(-1, -1, -1), 0, none_res},
      '{31'd0, mk_vec(12345, -678, 9), 1, none_res},
      '{31'd0, mk_vec(INT_MIN, INT_MAX, 0), 1, none_res},
      '{31'd0, mk_vec(0, 0, 0), 1, zero_res},
      '{RADIUS_MAX, mk_vec(INT_MAX, 0, 0), 0, none_res},
      '{RADIUS_MAX, mk_vec(0, INT_MIN, 0), 0, none_res},
      '{RADIUS_MAX, mk_vec(1, 1, 1), 0, none_res},
      '{RADIUS_MAX, mk_vec(-5, 7, INT_MIN), 0, none_res},
      '{RADIUS_MAX, mk_vec(0, 0, 0), 1, zero_res},
      '{31'h5555_5555, mk_vec(32'h5555_5555, -32'sh2aaa_aaab, 17), 0, none_res},
      '{31'h2aaa_aaaa, mk_vec(32'h2aaa_aaaa, 32'h5555_5555, -2), 0, none_res},
      '{31'd1, mk_vec(INT_MAX, INT_MAX, 0), 0, none_res},
      '{31'd1, mk_vec(-3, 0, 0), 0, none_res}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (rows[i]) begin
      if (rows[i].radius != radius_q) write_radius(rows[i].radius);
      send_vec(rows[i].vec, rows[i].check_row, rows[i].result);
    end

    // Random part, radius changed between phases.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 190 == 0) begin
        r = (i == 0) ? RADIUS_MAX : rand_radius();
        write_radius(r);
      end
      send_vec(mk_vec(rand_comp(), rand_comp(), rand_comp()), 0, none_res);
    end
    start <= 1'b0;

    while (scaled_q.size() != 0) @(posedge clk);
    repeat (vnr_pkg::LATENCY + 4) @(posedge clk);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
